// ===== rtl/rcfd_pkg.sv =====
// Package for the remote-control receiver frame decoder.
// Holds the frame geometry, register indexes, widths and shared types.
// No dependencies; the result interface and the top level import it.
`default_nettype none

package rcfd_pkg;

   // Frame geometry: the last byte is taken straight from the input.
   localparam int FRAME_LENGTH = 18;
   localparam int BUF_DEPTH    = FRAME_LENGTH - 1;
   localparam int IDX_W        = $clog2(FRAME_LENGTH);
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(FRAME_LENGTH - 1);

   // Field widths.
   localparam int CHAN_W   = 11;
   localparam int ZONE_W   = 10;
   localparam int WORD_W   = 16;
   localparam int SWITCH_W = 4;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_CENTER = 2'd0,
      CSR_DEAD_ZONE      = 2'd1,
      CSR_CHANNEL_LIMIT  = 2'd2
   } csr_index_type;

   // Register reset values.
   localparam logic [CHAN_W-1:0] CENTER_RESET = 11'd1024;
   localparam logic [ZONE_W-1:0] ZONE_RESET   = 10'd5;
   localparam logic [ZONE_W-1:0] LIMIT_RESET  = 10'd660;

   // Offset removed from the raw wheel word.
   localparam logic [WORD_W-1:0] WHEEL_OFFSET = 16'd1024;

   // One trimmed stick channel and its out-of-range flag.
   typedef struct packed {
      logic signed [CHAN_W-1:0] value;
      logic                     fault;
   } chan_result_type;

endpackage

`default_nettype wire

// ===== rtl/rcfd_req_if.sv =====
// Input channel of the frame decoder: one received byte per item.
// Does not import rcfd_pkg; plain valid/ready.
`default_nettype none

interface rcfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcfd_rsp_if.sv =====
// Result channel of the frame decoder: one decoded frame per item.
// Depends on rcfd_pkg for the field widths.
`default_nettype none

interface rcfd_rsp_if;
   import rcfd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [CHAN_W-1:0]   stick_one;
   logic signed [CHAN_W-1:0]   stick_two;
   logic signed [CHAN_W-1:0]   stick_three;
   logic signed [CHAN_W-1:0]   stick_four;
   logic        [SWITCH_W-1:0] switches;
   logic signed [WORD_W-1:0]   mouse_x;
   logic signed [WORD_W-1:0]   mouse_y;
   logic signed [WORD_W-1:0]   mouse_z;
   logic        [WORD_W-1:0]   mouse_buttons;
   logic        [WORD_W-1:0]   key_bits;
   logic signed [WORD_W-1:0]   wheel;
   logic                       range_fault;

   modport source (
      output valid, output stick_one, output stick_two, output stick_three,
      output stick_four, output switches, output mouse_x, output mouse_y,
      output mouse_z, output mouse_buttons, output key_bits, output wheel,
      output range_fault, input ready
   );
   modport sink (
      input valid, input stick_one, input stick_two, input stick_three,
      input stick_four, input switches, input mouse_x, input mouse_y,
      input mouse_z, input mouse_buttons, input key_bits, input wheel,
      input range_fault, output ready
   );
endinterface

`default_nettype wire

// ===== rtl/rc_receiver_frame_decoder_unit.sv =====
// Top level of the remote-control receiver frame decoder.
// Depends on rcfd_pkg, rcfd_req_if and rcfd_rsp_if.
//
// Usage:
//   req_if carries received bytes, one per item, with frame_start marking
//   byte 0 of a frame. A start mark mid-frame drops the partial frame.
//   Bytes 0 to 16 are stored in a 17-entry byte buffer; the 18th byte goes
//   straight into the decode logic together with the buffer, and the
//   decoded frame is loaded into the result register on that same edge.
//   After the 18th byte the count wraps, so the next byte opens a new frame.
//   rsp_if presents one item per complete frame, in the cycle after the last
//   byte is accepted. A byte is accepted every cycle; only a frame's last
//   byte waits, and only while the previous result is still held by the
//   receiver. Throughput is one byte per cycle outside that wait.
//   When a channel exceeds the limit, sticks read zero, range_fault is set,
//   and the mouse, button, key and wheel fields repeat their last good
//   values, which the result register itself keeps.
//   csr_we writes channel_center, dead_zone or channel_limit at csr_index;
//   write only while no frame is in progress or waiting.
//   Synchronous reset clears the byte count, the result valid flag, the
//   held fields and sets the registers to 1024, 5 and 660.
`default_nettype none

module rc_receiver_frame_decoder_unit (
   input  wire                               clock,
   input  wire                               reset,
   rcfd_req_if.sink                          req_if,
   rcfd_rsp_if.source                        rsp_if,
   input  wire                               csr_we,
   input  wire [rcfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [rcfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rcfd_pkg::*;

   // Center, dead-zone and range check for one stick channel.
   function automatic chan_result_type trim_channel(
      input logic [CHAN_W-1:0] raw,
      input logic [CHAN_W-1:0] center,
      input logic [ZONE_W-1:0] zone,
      input logic [ZONE_W-1:0] limit
   );
      chan_result_type    res;
      logic [CHAN_W:0]    diff;
      logic [CHAN_W-1:0]  mag;
      logic               dead;
      diff = {1'b0, raw} - {1'b0, center};
      mag  = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
      dead = mag <= {1'b0, zone};
      res.fault = !dead && (mag > {1'b0, limit});
      res.value = dead ? '0 : $signed(diff[CHAN_W-1:0]);
      return res;
   endfunction

   // Configuration registers.
   logic [CHAN_W-1:0] center_ff;
   logic [ZONE_W-1:0] zone_ff;
   logic [ZONE_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         zone_ff   <= ZONE_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_CENTER: center_ff <= csr_wdata;
            CSR_DEAD_ZONE:      zone_ff   <= csr_wdata[ZONE_W-1:0];
            CSR_CHANNEL_LIMIT:  limit_ff  <= csr_wdata[ZONE_W-1:0];
            default:            ;
         endcase
      end
   end

   // Byte count and frame buffer.
   logic [IDX_W-1:0] byte_index_ff;
   logic [IDX_W-1:0] byte_index_in;
   logic [IDX_W-1:0] wr_index;
   logic [7:0]       frame_ff [0:BUF_DEPTH-1];
   logic             req_accept;
   logic             frame_done;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   // The last byte stalls only while the previous result is still waiting.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready || (wr_index != LAST_INDEX);
   assign req_accept   = req_if.valid && req_if.ready;
   assign wr_index     = req_if.frame_start ? '0 : byte_index_ff;
   assign frame_done   = req_accept && (wr_index == LAST_INDEX);

   always_comb begin
      byte_index_in = byte_index_ff;
      if (req_accept) begin
         byte_index_in = frame_done ? '0 : wr_index + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && !frame_done) begin
         frame_ff[wr_index] <= req_if.rx_byte;
      end
   end

   // Unpack the sticks from bytes 0 to 5 and trim them.
   chan_result_type ch1, ch2, ch3, ch4;
   logic            fault;

   assign ch1 = trim_channel({frame_ff[1][2:0], frame_ff[0]}, center_ff, zone_ff, limit_ff);
   assign ch2 = trim_channel({frame_ff[2][5:0], frame_ff[1][7:3]}, center_ff, zone_ff,
                             limit_ff);
   assign ch3 = trim_channel({frame_ff[4][0], frame_ff[3], frame_ff[2][7:6]}, center_ff,
                             zone_ff, limit_ff);
   assign ch4 = trim_channel({frame_ff[5][3:0], frame_ff[4][7:1]}, center_ff, zone_ff,
                             limit_ff);
   assign fault = ch1.fault || ch2.fault || ch3.fault || ch4.fault;

   // Result register; its mouse, button, key and wheel fields are the held state.
   logic signed [CHAN_W-1:0]   stick1_ff, stick2_ff, stick3_ff, stick4_ff;
   logic        [SWITCH_W-1:0] switches_ff;
   logic        [WORD_W-1:0]   mouse_x_ff, mouse_y_ff, mouse_z_ff;
   logic        [WORD_W-1:0]   buttons_ff, keys_ff, wheel_ff;
   logic                       fault_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         stick1_ff   <= fault ? '0 : ch1.value;
         stick2_ff   <= fault ? '0 : ch2.value;
         stick3_ff   <= fault ? '0 : ch3.value;
         stick4_ff   <= fault ? '0 : ch4.value;
         switches_ff <= frame_ff[5][7:4];
         fault_ff    <= fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_x_ff <= '0;
         mouse_y_ff <= '0;
         mouse_z_ff <= '0;
         buttons_ff <= '0;
         keys_ff    <= '0;
         wheel_ff   <= '0;
      end else if (frame_done && !fault) begin
         mouse_x_ff <= {frame_ff[7], frame_ff[6]};
         mouse_y_ff <= {frame_ff[9], frame_ff[8]};
         mouse_z_ff <= {frame_ff[11], frame_ff[10]};
         buttons_ff <= {frame_ff[13], frame_ff[12]};
         keys_ff    <= {frame_ff[15], frame_ff[14]};
         wheel_ff   <= {req_if.rx_byte, frame_ff[16]} - WHEEL_OFFSET;
      end
   end

   // Drive the result channel.
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.stick_one     = stick1_ff;
   assign rsp_if.stick_two     = stick2_ff;
   assign rsp_if.stick_three   = stick3_ff;
   assign rsp_if.stick_four    = stick4_ff;
   assign rsp_if.switches      = switches_ff;
   assign rsp_if.mouse_x       = $signed(mouse_x_ff);
   assign rsp_if.mouse_y       = $signed(mouse_y_ff);
   assign rsp_if.mouse_z       = $signed(mouse_z_ff);
   assign rsp_if.mouse_buttons = buttons_ff;
   assign rsp_if.key_bits      = keys_ff;
   assign rsp_if.wheel         = $signed(wheel_ff);
   assign rsp_if.range_fault   = fault_ff;

`ifndef NO_ASSERTIONS
   // The byte count never runs past the last byte of a frame.
   assert property (@(posedge clock) disable iff (reset) byte_index_ff <= LAST_INDEX)
      else $error("byte count out of range");

   // A completed frame always shows up as a result on the next cycle.
   assert property (@(posedge clock) disable iff (reset) frame_done |=> rsp_valid_ff)
      else $error("completed frame produced no result");

   // A faulted result carries zero sticks.
   assert property (@(posedge clock) disable iff (reset)
      (frame_done && fault) |=> (stick1_ff == '0 && stick2_ff == '0 &&
                                 stick3_ff == '0 && stick4_ff == '0 && fault_ff))
      else $error("faulted frame has nonzero sticks");

   // A faulted frame leaves the held mouse, key and wheel fields alone.
   assert property (@(posedge clock) disable iff (reset)
      (frame_done && fault) |=> ($stable(mouse_x_ff) && $stable(keys_ff) &&
                                 $stable(wheel_ff) && $stable(buttons_ff)))
      else $error("held fields changed on a faulted frame");

   // The last byte is never taken while an unread result would be lost.
   assert property (@(posedge clock) disable iff (reset)
      (frame_done && rsp_valid_ff) |-> rsp_if.ready)
      else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire
